// ===== hw/rtl/pph_pkg.sv =====
// Package for the piecewise polynomial evaluator: field widths, request and
// register codes, default sizes and the status struct shared by all stages.
// No dependencies.
package pph_pkg;

    // default sizes handed to the top level
    localparam int MAX_ORDER_DEF  = 5;
    localparam int SEGMENTS_DEF   = 256;
    localparam int COEF_WIDTH_DEF = 48;

    // request channel field widths
    localparam int REQ_W     = 2;
    localparam int SEG_W     = 8;
    localparam int ORD_W     = 3;
    localparam int OFFSET_W  = 34;
    localparam int COEF_IN_W = 48;
    localparam int WIDTH_W   = 6;

    // result and datapath widths
    localparam int VALUE_W = 64;
    localparam int LO_W    = 32;
    localparam int PROD_W  = 98;
    localparam int FRAC_W  = 6;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WR_COEF  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_WIDTH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL     = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_FRAC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRY_UP     = 2'd2;

    // configuration reset values and limits
    localparam logic [ORD_W-1:0]  ORDER_RST  = 3'd5;
    localparam logic [FRAC_W-1:0] FRAC_RST   = 6'd18;
    localparam logic [FRAC_W-1:0] FRAC_MIN   = 6'd1;
    localparam logic [FRAC_W-1:0] FRAC_MAX   = 6'd32;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = 6'd2;

    typedef struct packed {
        logic seg_bad;
        logic range_err;
    } pph_stat_t;

endpackage

// ===== hw/rtl/pph_if.sv =====
// Channel interfaces of the piecewise polynomial evaluator: request, result
// and configuration write. Depends on pph_pkg.
interface pph_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [pph_pkg::REQ_W-1:0]             req_type;
    logic [pph_pkg::SEG_W-1:0]             segment;
    logic [pph_pkg::ORD_W-1:0]             order_index;
    logic signed [pph_pkg::OFFSET_W-1:0]   offset;
    logic signed [pph_pkg::COEF_IN_W-1:0]  coef_value;
    logic [pph_pkg::WIDTH_W-1:0]           width_value;

    modport source (output valid, req_type, segment, order_index, offset, coef_value,
                    width_value, input ready);
    modport sink (input valid, req_type, segment, order_index, offset, coef_value,
                  width_value, output ready);
endinterface

interface pph_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [pph_pkg::VALUE_W-1:0]  value;
    logic                                range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink (input valid, value, range_error, output ready);
endinterface

interface pph_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pph_pkg::CFG_IDX_W-1:0]     index;
    logic [pph_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pph_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pph_front.sv =====
// Request decode, coefficient RAMs (one per order), order width store and the
// first pipeline stage that captures an evaluate request.
// Depends on pph_pkg, pph_if and pph_ram.
module pph_front #(
    parameter int MAX_ORDER  = pph_pkg::MAX_ORDER_DEF,
    parameter int SEGMENTS   = pph_pkg::SEGMENTS_DEF,
    parameter int COEF_WIDTH = pph_pkg::COEF_WIDTH_DEF,
    localparam int NCOEF = MAX_ORDER + 1,
    localparam int SW = (COEF_WIDTH < pph_pkg::COEF_IN_W) ? COEF_WIDTH : pph_pkg::COEF_IN_W,
    localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    pph_req_if.sink                                req,
    input  logic [pph_pkg::ORD_W-1:0]              n,
    input  logic                                   dn_ready,
    output logic                                   dn_valid,
    output logic signed [pph_pkg::VALUE_W-1:0]     dn_z,
    output pph_pkg::pph_stat_t                     dn_stat,
    output logic signed [pph_pkg::OFFSET_W-1:0]    dn_dx,
    output logic [NCOEF-1:0][pph_pkg::WIDTH_W-1:0] dn_widths,
    output logic [NCOEF-1:0][SW-1:0]               dn_coefs
);

    logic                        en;
    logic                        fire;
    logic                        seg_ok;
    logic                        is_eval;
    logic                        coef_wr;
    logic                        width_wr;
    logic [AW-1:0]               seg_addr;
    logic [pph_pkg::WIDTH_W-1:0] w_clamp;

    logic [pph_pkg::WIDTH_W-1:0] width_reg [NCOEF];
    logic [NCOEF-1:0][pph_pkg::WIDTH_W-1:0] wd_next;

    logic                                 v_reg;
    logic signed [pph_pkg::OFFSET_W-1:0]  dx_reg;
    logic                                 bad_reg;
    logic [NCOEF-1:0][pph_pkg::WIDTH_W-1:0] wd_reg;

    assign en        = !v_reg || dn_ready;
    assign req.ready = en;
    assign fire      = req.valid && en;
    assign seg_ok    = 32'(req.segment) < 32'(SEGMENTS);
    assign is_eval   = req.req_type == pph_pkg::REQ_EVAL;
    assign coef_wr   = fire && (req.req_type == pph_pkg::REQ_WR_COEF) && seg_ok;
    assign width_wr  = fire && (req.req_type == pph_pkg::REQ_WR_WIDTH);
    assign seg_addr  = AW'(req.segment);

    always @(*)
    begin
        if (req.width_value < pph_pkg::WIDTH_MIN)
            w_clamp = pph_pkg::WIDTH_MIN;
        else if (req.width_value > pph_pkg::WIDTH_W'(COEF_WIDTH))
            w_clamp = pph_pkg::WIDTH_W'(COEF_WIDTH);
        else
            w_clamp = req.width_value;
    end

    for (genvar j = 0; j < NCOEF; j++)
    begin : g_order
        logic we_j;

        assign we_j = coef_wr && ({1'b0, req.order_index} == 4'(j));

        pph_ram #(
            .WIDTH (SW),
            .DEPTH (SEGMENTS)
        ) u_coef_ram (
            .clk   (clk),
            .we    (we_j),
            .waddr (seg_addr),
            .wdata (req.coef_value[SW-1:0]),
            .re    (fire && is_eval),
            .raddr (seg_addr),
            .rdata (dn_coefs[j])
        );

        always_ff @(posedge clk)
        begin
            if (width_wr && ({1'b0, req.order_index} == 4'(j)))
            begin
                width_reg[j] <= w_clamp;
            end
        end

        // an entry below the minimum width counts as the minimum, one above COEF_WIDTH as COEF_WIDTH
        assign wd_next[j] = (width_reg[j] < pph_pkg::WIDTH_MIN) ? pph_pkg::WIDTH_MIN :
                            (width_reg[j] > pph_pkg::WIDTH_W'(COEF_WIDTH)) ?
                            pph_pkg::WIDTH_W'(COEF_WIDTH) : width_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= fire && is_eval;
        end
    end

    // snapshot widths so a later width write cannot reach an item in flight
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= req.offset;
            bad_reg <= !seg_ok;
            wd_reg  <= wd_next;
        end
    end

    // start Horner's rule from the top coefficient in use
    always @(*)
    begin
        dn_z = '0;
        for (int j = 0; j < NCOEF; j++)
        begin
            if ({1'b0, n} == 4'(j))
                dn_z = pph_pkg::VALUE_W'($signed(dn_coefs[j]));
        end
    end

    assign dn_valid          = v_reg;
    assign dn_stat.seg_bad   = bad_reg;
    assign dn_stat.range_err = 1'b0;
    assign dn_dx             = dx_reg;
    assign dn_widths         = wd_reg;

endmodule

// ===== hw/rtl/pph_step.sv =====
// One Horner step for a fixed order, four register stages: offset scaling,
// split partial products, recombine and floor shift, saturating add with the
// range check. Depends on pph_pkg.
module pph_step #(
    parameter int ORD       = 1,
    parameter int MAX_ORDER = pph_pkg::MAX_ORDER_DEF,
    parameter int SW        = pph_pkg::COEF_IN_W,
    localparam int NCOEF = MAX_ORDER + 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [pph_pkg::ORD_W-1:0]              n,
    input  logic [pph_pkg::FRAC_W-1:0]             frac,
    input  logic                                   carry_up,
    input  logic                                   up_valid,
    output logic                                   up_ready,
    input  logic signed [pph_pkg::VALUE_W-1:0]     up_z,
    input  pph_pkg::pph_stat_t                     up_stat,
    input  logic signed [pph_pkg::OFFSET_W-1:0]    up_dx,
    input  logic [NCOEF-1:0][pph_pkg::WIDTH_W-1:0] up_widths,
    input  logic [NCOEF-1:0][SW-1:0]               up_coefs,
    output logic                                   dn_valid,
    input  logic                                   dn_ready,
    output logic signed [pph_pkg::VALUE_W-1:0]     dn_z,
    output pph_pkg::pph_stat_t                     dn_stat,
    output logic signed [pph_pkg::OFFSET_W-1:0]    dn_dx,
    output logic [NCOEF-1:0][pph_pkg::WIDTH_W-1:0] dn_widths,
    output logic [NCOEF-1:0][SW-1:0]               dn_coefs
);

    localparam int VW = pph_pkg::VALUE_W;
    localparam int OW = pph_pkg::OFFSET_W;
    localparam int PW = pph_pkg::PROD_W;
    localparam int LW = pph_pkg::LO_W;
    localparam int WW = pph_pkg::WIDTH_W;
    localparam int FW = pph_pkg::FRAC_W;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef logic [NCOEF-1:0][WW-1:0] wd_t;
    typedef logic [NCOEF-1:0][SW-1:0] cf_t;

    logic en_a, en_b, en_c, en_d;
    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg;

    // stage A
    logic                    act_next;
    logic signed [OW-1:0]    xl_next;
    logic [FW-1:0]           s_next;
    logic [FW-1:0]           k_next;
    logic [WW-1:0]           wi;
    logic                    act_a_reg;
    logic signed [OW-1:0]    xl_a_reg;
    logic [FW-1:0]           s_a_reg;
    logic signed [VW-1:0]    z_a_reg;
    pph_pkg::pph_stat_t      st_a_reg;
    logic signed [OW-1:0]    dx_a_reg;
    wd_t                     wd_a_reg;
    cf_t                     cf_a_reg;

    // stage B
    logic signed [LW:0]      zl;
    logic signed [LW-1:0]    zh;
    logic signed [LW+OW:0]   pl_next;
    logic signed [LW+OW-1:0] ph_next;
    logic signed [LW+OW:0]   pl_b_reg;
    logic signed [LW+OW-1:0] ph_b_reg;
    logic                    act_b_reg;
    logic [FW-1:0]           s_b_reg;
    logic signed [VW-1:0]    z_b_reg;
    pph_pkg::pph_stat_t      st_b_reg;
    logic signed [OW-1:0]    dx_b_reg;
    wd_t                     wd_b_reg;
    cf_t                     cf_b_reg;

    // stage C
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    q_next;
    logic [WW:0]             cw;
    logic signed [VW-1:0]    lim_next;
    logic signed [PW-1:0]    q_c_reg;
    logic signed [VW-1:0]    lim_c_reg;
    logic                    act_c_reg;
    logic signed [VW-1:0]    z_c_reg;
    pph_pkg::pph_stat_t      st_c_reg;
    logic signed [OW-1:0]    dx_c_reg;
    wd_t                     wd_c_reg;
    cf_t                     cf_c_reg;

    // stage D
    logic [PW-VW:0]          q_hi;
    logic signed [VW-1:0]    p_sat;
    logic signed [VW-1:0]    c_ext;
    logic signed [VW:0]      sum;
    logic signed [VW-1:0]    z_next;
    logic                    err_next;
    logic signed [VW-1:0]    z_d_reg;
    pph_pkg::pph_stat_t      st_d_reg;
    logic signed [OW-1:0]    dx_d_reg;
    wd_t                     wd_d_reg;
    cf_t                     cf_d_reg;

    assign en_d     = !v_d_reg || dn_ready;
    assign en_c     = !v_c_reg || en_d;
    assign en_b     = !v_b_reg || en_c;
    assign en_a     = !v_a_reg || en_b;
    assign up_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                v_a_reg <= up_valid;
            if (en_b)
                v_b_reg <= v_a_reg;
            if (en_c)
                v_c_reg <= v_b_reg;
            if (en_d)
                v_d_reg <= v_c_reg;
        end
    end

    // stage A: bring the offset down to this order's width
    always @(*)
    begin
        wi       = up_widths[ORD];
        act_next = {1'b0, n} >= 4'(ORD);
        k_next   = '0;
        if (frac > wi)
        begin
            k_next  = frac - wi;
            xl_next = up_dx >>> k_next;
            s_next  = wi;
        end
        else
        begin
            xl_next = up_dx;
            s_next  = frac;
        end
    end

    // stage B: two partial products on the low and high halves of z
    always @(*)
    begin
        zl      = $signed({1'b0, z_a_reg[LW-1:0]});
        zh      = z_a_reg[VW-1:LW];
        pl_next = zl * xl_a_reg;
        ph_next = zh * xl_a_reg;
    end

    // stage C: recombine, floor shift, range limit for the next coefficient
    always @(*)
    begin
        prod     = (PW'(ph_b_reg) <<< LW) + PW'(pl_b_reg);
        q_next   = prod >>> s_b_reg;
        cw       = (WW+1)'(wd_b_reg[ORD-1]) + (WW+1)'(carry_up);
        lim_next = VW'(1) << (cw - (WW+1)'(1));
    end

    // stage D: saturate, add the next coefficient, check its range
    always @(*)
    begin
        q_hi = q_c_reg[PW-1:VW-1];
        if ((&q_hi) || !(|q_hi))
            p_sat = q_c_reg[VW-1:0];
        else if (q_c_reg[PW-1])
            p_sat = VMIN;
        else
            p_sat = VMAX;
        c_ext = VW'($signed(cf_c_reg[ORD-1]));
        sum   = (VW+1)'(p_sat) + (VW+1)'(c_ext);
        if (sum[VW] != sum[VW-1])
            z_next = sum[VW] ? VMIN : VMAX;
        else
            z_next = sum[VW-1:0];
        err_next = st_c_reg.range_err || (z_next >= lim_c_reg) || (z_next < -lim_c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            act_a_reg <= act_next;
            xl_a_reg  <= xl_next;
            s_a_reg   <= s_next;
            z_a_reg   <= up_z;
            st_a_reg  <= up_stat;
            dx_a_reg  <= up_dx;
            wd_a_reg  <= up_widths;
            cf_a_reg  <= up_coefs;
        end
        if (en_b)
        begin
            pl_b_reg  <= pl_next;
            ph_b_reg  <= ph_next;
            act_b_reg <= act_a_reg;
            s_b_reg   <= s_a_reg;
            z_b_reg   <= z_a_reg;
            st_b_reg  <= st_a_reg;
            dx_b_reg  <= dx_a_reg;
            wd_b_reg  <= wd_a_reg;
            cf_b_reg  <= cf_a_reg;
        end
        if (en_c)
        begin
            q_c_reg   <= q_next;
            lim_c_reg <= lim_next;
            act_c_reg <= act_b_reg;
            z_c_reg   <= z_b_reg;
            st_c_reg  <= st_b_reg;
            dx_c_reg  <= dx_b_reg;
            wd_c_reg  <= wd_b_reg;
            cf_c_reg  <= cf_b_reg;
        end
        if (en_d)
        begin
            // orders above the one in use pass the value through
            if (act_c_reg)
            begin
                z_d_reg            <= z_next;
                st_d_reg.range_err <= err_next;
            end
            else
            begin
                z_d_reg            <= z_c_reg;
                st_d_reg.range_err <= st_c_reg.range_err;
            end
            st_d_reg.seg_bad <= st_c_reg.seg_bad;
            dx_d_reg         <= dx_c_reg;
            wd_d_reg         <= wd_c_reg;
            cf_d_reg         <= cf_c_reg;
        end
    end

    assign dn_valid  = v_d_reg;
    assign dn_z      = z_d_reg;
    assign dn_stat   = st_d_reg;
    assign dn_dx     = dx_d_reg;
    assign dn_widths = wd_d_reg;
    assign dn_coefs  = cf_d_reg;

endmodule

// ===== hw/rtl/piecewise_poly_horner_fixed_top.sv =====
// Top level of the piecewise polynomial evaluator: configuration registers,
// request front end, one Horner step per order and the result register.
// Depends on pph_pkg, pph_if, pph_front and pph_step.
//
// The block takes one request per cycle while no stall holds the pipeline.
// Coefficient and width writes finish at the clock edge that accepts them and
// give no result. An evaluate request gives one result after the coefficient
// RAM read, four register stages per Horner step (offset scaling, 32-bit split
// partial products, recombine and floor shift, saturating add with range check)
// and the result register. Every order from 1 to MAX_ORDER has its own step, so
// the latency does not depend on order_in_use. Results leave in request order;
// a stalled result channel holds the pipeline, and requests keep entering
// while empty stages remain. Configuration writes are taken in every cycle and
// must only be made while no evaluation is in flight.
module piecewise_poly_horner_fixed_top #(
    parameter int MAX_ORDER  = pph_pkg::MAX_ORDER_DEF,
    parameter int SEGMENTS   = pph_pkg::SEGMENTS_DEF,
    parameter int COEF_WIDTH = pph_pkg::COEF_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pph_req_if.sink    req,
    pph_res_if.source  res,
    pph_cfg_if.sink    cfg
);

    localparam int NCOEF = MAX_ORDER + 1;
    localparam int SW = (COEF_WIDTH < pph_pkg::COEF_IN_W) ? COEF_WIDTH : pph_pkg::COEF_IN_W;
    localparam int VW = pph_pkg::VALUE_W;
    localparam int OW = pph_pkg::OFFSET_W;
    localparam int WW = pph_pkg::WIDTH_W;
    localparam int FW = pph_pkg::FRAC_W;
    localparam int DW = pph_pkg::ORD_W;

    logic [DW-1:0] order_reg;
    logic [FW-1:0] frac_reg;
    logic          carry_reg;
    logic [DW-1:0] n_eff;
    logic [FW-1:0] frac_eff;

    logic [MAX_ORDER:0]              v_s;
    logic [MAX_ORDER:0]              rdy_s;
    logic signed [VW-1:0]            z_s  [MAX_ORDER+1];
    pph_pkg::pph_stat_t              st_s [MAX_ORDER+1];
    logic signed [OW-1:0]            dx_s [MAX_ORDER+1];
    logic [NCOEF-1:0][WW-1:0]        wd_s [MAX_ORDER+1];
    logic [NCOEF-1:0][SW-1:0]        cf_s [MAX_ORDER+1];

    logic                 out_v_reg;
    logic signed [VW-1:0] value_reg;
    logic                 err_reg;
    logic                 en_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= pph_pkg::ORDER_RST;
            frac_reg  <= pph_pkg::FRAC_RST;
            carry_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pph_pkg::CFG_ORDER_IN_USE: order_reg <= cfg.data[DW-1:0];
                pph_pkg::CFG_OFFSET_FRAC:  frac_reg  <= cfg.data[FW-1:0];
                pph_pkg::CFG_CARRY_UP:     carry_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // clamp the order and the fraction bits to what the datapath supports
    always @(*)
    begin
        if (4'(order_reg) > 4'(MAX_ORDER))
            n_eff = DW'(MAX_ORDER);
        else
            n_eff = order_reg;
        if (frac_reg < pph_pkg::FRAC_MIN)
            frac_eff = pph_pkg::FRAC_MIN;
        else if (frac_reg > pph_pkg::FRAC_MAX)
            frac_eff = pph_pkg::FRAC_MAX;
        else
            frac_eff = frac_reg;
    end

    pph_front #(
        .MAX_ORDER  (MAX_ORDER),
        .SEGMENTS   (SEGMENTS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .n         (n_eff),
        .dn_ready  (rdy_s[0]),
        .dn_valid  (v_s[0]),
        .dn_z      (z_s[0]),
        .dn_stat   (st_s[0]),
        .dn_dx     (dx_s[0]),
        .dn_widths (wd_s[0]),
        .dn_coefs  (cf_s[0])
    );

    // step k works on order MAX_ORDER-k+1, top order first
    for (genvar k = 1; k <= MAX_ORDER; k++)
    begin : g_step
        pph_step #(
            .ORD       (MAX_ORDER - k + 1),
            .MAX_ORDER (MAX_ORDER),
            .SW        (SW)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .n         (n_eff),
            .frac      (frac_eff),
            .carry_up  (carry_reg),
            .up_valid  (v_s[k-1]),
            .up_ready  (rdy_s[k-1]),
            .up_z      (z_s[k-1]),
            .up_stat   (st_s[k-1]),
            .up_dx     (dx_s[k-1]),
            .up_widths (wd_s[k-1]),
            .up_coefs  (cf_s[k-1]),
            .dn_valid  (v_s[k]),
            .dn_ready  (rdy_s[k]),
            .dn_z      (z_s[k]),
            .dn_stat   (st_s[k]),
            .dn_dx     (dx_s[k]),
            .dn_widths (wd_s[k]),
            .dn_coefs  (cf_s[k])
        );
    end

    assign en_out           = !out_v_reg || res.ready;
    assign rdy_s[MAX_ORDER] = en_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_v_reg <= v_s[MAX_ORDER];
        end
    end

    // a segment beyond the table answers zero with the error flag
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            value_reg <= st_s[MAX_ORDER].seg_bad ? '0 : z_s[MAX_ORDER];
            err_reg   <= st_s[MAX_ORDER].seg_bad || st_s[MAX_ORDER].range_err;
        end
    end

    assign res.valid       = out_v_reg;
    assign res.value       = value_reg;
    assign res.range_error = err_reg;

endmodule

// ===== hw/rtl/pph_checker.sv =====
// Port-level checks for the piecewise polynomial evaluator, bound to the top
// level. Depends on pph_pkg and piecewise_poly_horner_fixed_top.
module pph_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic [pph_pkg::REQ_W-1:0]         req_type,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [pph_pkg::VALUE_W-1:0]       res_value,
    input logic                              res_error,
    input logic                              cfg_ready
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       eval_in;
    logic       res_out;

    assign eval_in = req_valid && req_ready && (req_type == pph_pkg::REQ_EVAL);
    assign res_out = res_valid && res_ready;

    always @(*)
    begin
        pend_next = pend_reg + 8'(eval_in) - 8'(res_out);
    end

    // count evaluate requests whose result is still owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_res_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 8'd0)
        else $error("result offered with no evaluate request outstanding");

    a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_error))
        else $error("stalled result changed or dropped");

    a_clean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_error |-> res_value[pph_pkg::VALUE_W-1] == res_value[pph_pkg::VALUE_W-2])
        else $error("result without range error lies beyond any coefficient width");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port refused a write");

endmodule

bind piecewise_poly_horner_fixed_top pph_checker u_pph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_value (res.value),
    .res_error (res.range_error),
    .cfg_ready (cfg.ready)
);

// ===== test/piecewise_poly_horner_fixed_top_tb.sv =====
// Testbench for piecewise_poly_horner_fixed_top: drives table writes and evaluate requests,
// predicts each Horner result with exact 128-bit integer arithmetic and checks it.
// Depends on pph_pkg, pph_if and the block's RTL.
`timescale 1ns / 100ps

module piecewise_poly_horner_fixed_top_tb;
    import pph_pkg::*;

    localparam int MAX_ORD = MAX_ORDER_DEF;
    localparam int SEGS    = SEGMENTS_DEF;
    localparam int CW      = COEF_WIDTH_DEF;
    localparam int NCOEF   = MAX_ORD + 1;
    localparam int LATENCY = 2 + 4 * MAX_ORD;
    localparam int SETTLE  = LATENCY + 8;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [127:0] INT64_HI = 128'sh7fff_ffff_ffff_ffff;
    localparam logic signed [127:0] INT64_LO = -INT64_HI - 128'sd1;

    typedef struct packed {
        logic [REQ_W-1:0]            kind;
        logic [SEG_W-1:0]            segment;
        logic [ORD_W-1:0]            order_index;
        logic signed [OFFSET_W-1:0]  offset;
        logic signed [COEF_IN_W-1:0] coef_value;
        logic [WIDTH_W-1:0]          width_value;
    } pph_request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      range_error;
    } eval_result_t;

    logic clk;
    logic rst_n;

    pph_req_if req_ch ();
    pph_res_if res_ch ();
    pph_cfg_if cfg_ch ();

    piecewise_poly_horner_fixed_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predicted tables and registers
    logic signed [COEF_IN_W-1:0] coef_mem [SEGS][NCOEF];
    logic [WIDTH_W-1:0]          width_mem [NCOEF];
    logic [NCOEF-1:0]            coef_written [SEGS];
    logic [NCOEF-1:0]            width_written;
    logic [ORD_W-1:0]            order_sel;
    logic [FRAC_W-1:0]           frac_sel;
    logic                        carry_sel;

    eval_result_t pending_results [$];
    eval_result_t head;
    int           mismatches;
    int           work_items;
    bit           req_idle;
    bit           res_idle;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what,
                 $signed(got), $signed(want));
        mismatches++;
    endtask

    function automatic int order_eff();
        return (order_sel > MAX_ORD) ? MAX_ORD : int'(order_sel);
    endfunction

    function automatic int frac_eff();
        if (frac_sel < FRAC_MIN)
            return FRAC_MIN;
        if (frac_sel > FRAC_MAX)
            return FRAC_MAX;
        return frac_sel;
    endfunction

    function automatic int width_of(input int ord);
        return (width_mem[ord] < WIDTH_MIN) ? WIDTH_MIN : int'(width_mem[ord]);
    endfunction

    function automatic logic signed [63:0] clip64(input logic signed [127:0] v);
        if (v > INT64_HI)
            return INT64_HI[63:0];
        if (v < INT64_LO)
            return INT64_LO[63:0];
        return v[63:0];
    endfunction

    // Horner's rule from the top order down, floor shifts and saturation throughout
    function automatic eval_result_t horner_eval(input logic [SEG_W-1:0] seg,
                                                 input logic signed [OFFSET_W-1:0] dx);
        eval_result_t r;
        int n, frac, wi, cw, s, i;
        logic signed [63:0] z, xl;
        logic signed [127:0] zw, xw, term, lim;
        n = order_eff();
        frac = frac_eff();
        z = coef_mem[seg][n];
        r.range_error = 1'b0;
        for (i = n; i > 0; i--)
        begin
            wi = width_of(i);
            xl = dx;
            s = frac;
            if (frac > wi)
            begin
                xl = dx >>> (frac - wi);
                s = wi;
            end
            zw = z;
            xw = xl;
            term = clip64((zw * xw) >>> s);
            zw = coef_mem[seg][i - 1];
            z = clip64(term + zw);
            cw = width_of(i - 1) + int'(carry_sel);
            lim = 128'sd1 <<< (cw - 1);
            zw = z;
            if (zw >= lim || zw < -lim)
                r.range_error = 1'b1;
        end
        r.value = z;
        return r;
    endfunction

    function automatic void apply_to_tables(input pph_request_t r);
        int w;
        case (r.kind)
            REQ_WR_COEF:
            begin
                if (r.order_index <= MAX_ORD)
                begin
                    coef_mem[r.segment][r.order_index] = r.coef_value;
                    coef_written[r.segment][r.order_index] = 1'b1;
                end
            end
            REQ_WR_WIDTH:
            begin
                w = r.width_value;
                if (w < WIDTH_MIN)
                    w = WIDTH_MIN;
                if (w > CW)
                    w = CW;
                if (r.order_index <= MAX_ORD)
                begin
                    width_mem[r.order_index] = w;
                    width_written[r.order_index] = 1'b1;
                end
            end
            REQ_EVAL:
            begin
                if (r.segment >= SEGS)
                    pending_results.push_back('{value: '0, range_error: 1'b1});
                else
                    pending_results.push_back(horner_eval(r.segment, r.offset));
            end
            default: ;
        endcase
        if (r.kind != REQ_UNUSED && (r.kind == REQ_EVAL || r.order_index <= MAX_ORD))
            work_items++;
    endfunction

    // a segment may be evaluated only once every entry it reads has been written
    function automatic bit segment_ready(input int seg);
        logic [NCOEF-1:0] need;
        need = (1 << (order_eff() + 1)) - 1;
        return ((coef_written[seg] & need) == need) && ((width_written & need) == need);
    endfunction

    function automatic pph_request_t random_request();
        pph_request_t r;
        r.kind        = $urandom_range(0, 3);
        r.segment     = $urandom;
        r.order_index = $urandom;
        r.offset      = {$urandom, $urandom};
        r.coef_value  = {$urandom, $urandom};
        r.width_value = $urandom;
        return r;
    endfunction

    function automatic logic signed [COEF_IN_W-1:0] rand_coef(input int w);
        logic signed [COEF_IN_W-1:0] v;
        int mode, keep;
        v = {$urandom, $urandom};
        mode = $urandom_range(0, 9);
        keep = w;
        if (mode == 0)
            return v;
        if (mode == 1)
            return $urandom_range(0, 1) ? {1'b0, {47{1'b1}}} : {1'b1, {47{1'b0}}};
        // keep well inside the width now and then
        if (mode < 4 && w > 6)
            keep = $urandom_range(2, w - 4);
        v = v <<< (COEF_IN_W - keep);
        return v >>> (COEF_IN_W - keep);
    endfunction

    function automatic logic signed [OFFSET_W-1:0] rand_offset();
        logic signed [OFFSET_W-1:0] v;
        int mode, f;
        f = frac_eff();
        v = {$urandom, $urandom};
        mode = $urandom_range(0, 19);
        case (mode)
            0: return {1'b0, {33{1'b1}}};
            1: return {1'b1, {33{1'b0}}};
            2: return '0;
            3: return '1;
            4, 5, 6: return v;
            default:
            begin
                // within one unit either side of the segment origin
                v = v <<< (OFFSET_W - 1 - f);
                return v >>> (OFFSET_W - 1 - f);
            end
        endcase
    endfunction

    function automatic int rand_width();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(8, 44);
    endfunction

    task automatic send_request(input pph_request_t r);
        int gap;
        gap = req_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.kind;
        req_ch.segment     <= r.segment;
        req_ch.order_index <= r.order_index;
        req_ch.offset      <= r.offset;
        req_ch.coef_value  <= r.coef_value;
        req_ch.width_value <= r.width_value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_to_tables(r);
    endtask

    task automatic release_request();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_ORDER_IN_USE: order_sel = data[ORD_W-1:0];
            CFG_OFFSET_FRAC:  frac_sel = data;
            CFG_CARRY_UP:     carry_sel = data[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // registers change only with the pipeline empty
    task automatic apply_settings(input int order, input int frac, input int carry);
        release_request();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_register(CFG_ORDER_IN_USE, {3'($urandom), 3'(order)});
        write_register(CFG_OFFSET_FRAC, 6'(frac));
        write_register(CFG_CARRY_UP, {5'($urandom), 1'(carry)});
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_coef(input int seg, input int ord,
                              input logic signed [COEF_IN_W-1:0] v);
        pph_request_t r;
        r = random_request();
        r.kind = REQ_WR_COEF;
        r.segment = 8'(seg);
        r.order_index = 3'(ord);
        r.coef_value = v;
        send_request(r);
    endtask

    task automatic send_width(input int ord, input int w);
        pph_request_t r;
        r = random_request();
        r.kind = REQ_WR_WIDTH;
        r.order_index = 3'(ord);
        r.width_value = 6'(w);
        send_request(r);
    endtask

    task automatic send_eval(input int seg, input logic signed [OFFSET_W-1:0] dx);
        pph_request_t r;
        r = random_request();
        r.kind = REQ_EVAL;
        r.segment = 8'(seg);
        r.offset = dx;
        send_request(r);
    endtask

    task automatic send_noise();
        pph_request_t r;
        r = random_request();
        r.kind = REQ_UNUSED;
        send_request(r);
    endtask

    task automatic send_eval_any();
        int ready_segs [$];
        int s;
        for (s = 0; s < SEGS; s++)
            if (segment_ready(s))
                ready_segs.push_back(s);
        if (ready_segs.size() != 0)
            send_eval(ready_segs[$urandom_range(0, ready_segs.size() - 1)], rand_offset());
    endtask

    task automatic write_width_set();
        int o;
        for (o = 0; o < NCOEF; o++)
            send_width(o, $urandom_range(10, 40));
    endtask

    // load a whole segment in scrambled order, then probe it
    task automatic fill_segment_and_probe();
        int seg, first, k, o;
        seg = $urandom_range(0, SEGS - 1);
        first = $urandom_range(0, NCOEF - 1);
        for (k = 0; k < NCOEF; k++)
        begin
            o = (first + k) % NCOEF;
            write_coef(seg, o, rand_coef(width_of(o)));
        end
        repeat ($urandom_range(1, 3)) send_eval(seg, rand_offset());
    endtask

    task automatic run_random_traffic(input int n_items);
        int target, pick;
        target = work_items + n_items;
        write_width_set();
        while (work_items < target)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                req_idle = ($urandom_range(0, 2) != 0);
                res_idle = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 18)
                fill_segment_and_probe();
            else if (pick < 64)
                send_eval_any();
            else if (pick < 76)
                write_coef($urandom_range(0, SEGS - 1), $urandom_range(0, 7),
                           rand_coef($urandom_range(2, CW)));
            else if (pick < 86)
                send_width($urandom_range(0, 7), rand_width());
            else if (pick < 90)
                write_width_set();
            else
                send_noise();
        end
    endtask

    task automatic test_directed_extremes();
        // width clamping at both ends, plus a write to an order that does not exist
        send_width(0, 48);
        send_width(1, 0);
        send_width(2, 63);
        send_width(3, 1);
        send_width(4, 2);
        send_width(5, 20);
        send_width(6, 9);
        write_coef(255, 0, {1'b0, {47{1'b1}}});
        write_coef(255, 1, {1'b1, {47{1'b0}}});
        write_coef(255, 2, '1);
        write_coef(255, 3, 48'sd1);
        write_coef(255, 4, {1'b0, {47{1'b1}}});
        write_coef(255, 5, {1'b1, {47{1'b0}}});
        write_coef(255, 7, 48'sd12345);
        send_eval(255, {1'b0, {33{1'b1}}});
        send_eval(255, {1'b1, {33{1'b0}}});
        send_eval(255, '0);
        send_eval(255, 34'sd1);
        send_eval(255, '1);
        send_noise();
    endtask

    task automatic test_default_settings();
        apply_settings(ORDER_RST, FRAC_RST, 0);
        run_random_traffic(110);
    endtask

    task automatic test_order_zero();
        // fraction count of zero behaves as one
        apply_settings(0, 0, 1);
        run_random_traffic(60);
    endtask

    task automatic test_clamped_settings();
        apply_settings(7, 63, 0);
        run_random_traffic(100);
    endtask

    task automatic test_carry_up();
        apply_settings(3, 32, 1);
        run_random_traffic(100);
    endtask

    task automatic test_pause_with_backlog();
        apply_settings(1, 1, 0);
        run_random_traffic(40);
        // hold requests back until every result is out
        release_request();
        wait_drained();
        run_random_traffic(40);
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            apply_settings($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 1));
            run_random_traffic(35);
        end
    endtask

    // result side: while res_idle is set, stall for a drawn number of cycles before each result
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = res_idle ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request pending", res_ch.value, '0);
            else
            begin
                head = pending_results.pop_front();
                if (res_ch.value !== head.value)
                    report_mismatch("value", res_ch.value, head.value);
                if (res_ch.range_error !== head.range_error)
                    report_mismatch("range_error", 64'(res_ch.range_error),
                                    64'(head.range_error));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_WR_COEF;
        req_ch.segment = '0;
        req_ch.order_index = '0;
        req_ch.offset = '0;
        req_ch.coef_value = '0;
        req_ch.width_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ORDER_IN_USE;
        cfg_ch.data = '0;
        mismatches = 0;
        work_items = 0;
        req_idle = 1'b1;
        res_idle = 1'b1;
        order_sel = ORDER_RST;
        frac_sel = FRAC_RST;
        carry_sel = 1'b0;
        width_written = '0;
        foreach (coef_written[s])
            coef_written[s] = '0;
        foreach (width_mem[o])
            width_mem[o] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_default_settings();
        test_order_zero();
        test_clamped_settings();
        test_carry_up();
        test_pause_with_backlog();
        test_random_settings();

        release_request();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pph_pkg.sv
hw/rtl/pph_if.sv
hw/rtl/pph_ram.sv
hw/rtl/pph_front.sv
hw/rtl/pph_step.sv
hw/rtl/piecewise_poly_horner_fixed_top.sv
hw/rtl/pph_checker.sv
test/piecewise_poly_horner_fixed_top_tb.sv
